@@ hw/rtl/rits_pkg.sv @@
// Package for the radix integer-to-symbols converter: payload structs,
// state encoding, character codes and default parameter values.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package rits_pkg;

  // Widths of the fixed fields.
  localparam int RADIX_W  = 7;
  localparam int CHAR_W   = 8;
  localparam int SYMIDX_W = 6;
  localparam int VALUE_W  = 32;

  // Default parameter values for the top level.
  localparam int MAX_RADIX_DEF   = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Register reset value and special character codes.
  localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
  localparam logic [CHAR_W-1:0]  CHAR_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0]  CHAR_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 8'h2D;

  // Operation codes of an input item.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef struct packed {
    logic                       operation;
    logic [SYMIDX_W-1:0]        symbol_index;
    logic [CHAR_W-1:0]          symbol_code;
    logic signed [VALUE_W-1:0]  value;
  } rits_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } rits_out_t;

  // Result of a base check, reported for one cycle.
  typedef struct packed {
    logic done;
    logic ok;
  } rits_check_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIVIDE,
    S_SIGN,
    S_STACK,
    S_TABLE,
    S_PUT
  } rits_state_e;

endpackage

@@ hw/rtl/radix_integer_to_symbols.sv @@
// Top level of the radix integer-to-symbols converter: control sequencer,
// digit stack, output register. Uses rits_pkg and the modules of rits_*.
`timescale 1ns / 1ps

// A load item writes one symbol into the table. A convert item first
// checks the base: the checker reads one symbol per cycle from the table
// memory. Each digit then comes from the bit-serial divider, and each digit
// character leaves through the digit stack and the table read port, after
// a minus sign for a negative value; out_ready_i can hold them back. The
// last character waits in the output register while the next item is
// taken.
// No clearing pass follows reset; table entries must be loaded before use.
module radix_integer_to_symbols import rits_pkg::*; #(
  parameter int MAX_RADIX   = MAX_RADIX_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rits_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rits_out_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RADIX_W-1:0] cfg_data_i
);

  localparam int IDX_W  = $clog2(MAX_RADIX);
  localparam int DIG_W  = IDX_W;
  localparam int STK_W  = $clog2(VALUE_WIDTH);
  localparam int DCNT_W = $clog2(VALUE_WIDTH + 1);

  rits_state_e            state_q, state_d;
  logic [RADIX_W-1:0]     radix_q;
  logic                   neg_q;
  logic [VALUE_WIDTH-1:0] mag_q;
  logic [DCNT_W-1:0]      dcnt_q, dcnt_m1;
  logic [DIG_W-1:0]       stk_mem [VALUE_WIDTH];
  logic [DIG_W-1:0]       stk_rd_q;
  logic                   out_valid_q;
  rits_out_t              out_data_q, out_d;

  logic                   in_xfer, chk_start, div_start, stk_wr, stk_rd, tbl_rd;
  logic                   out_load, slot_free, ram_wr, ram_rd;
  logic [IDX_W-1:0]       ram_rd_addr, chk_addr;
  logic                   chk_rd;
  logic [CHAR_W-1:0]      ram_data;
  rits_check_t            chk_status;
  logic                   div_done, div_nz;
  logic [VALUE_WIDTH-1:0] div_quot, div_dividend;
  logic [RADIX_W-1:0]     div_rem;
  logic signed [63:0]     val_ext;
  logic [VALUE_WIDTH-1:0] val_w, val_mag;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign dcnt_m1   = dcnt_q - 1'b1;

  // Input value sign-extended, cut to the working width, made a magnitude.
  assign val_ext = 64'(in_data_i.value);
  assign val_w   = val_ext[VALUE_WIDTH-1:0];
  assign val_mag = val_w[VALUE_WIDTH-1] ? (~val_w + 1'b1) : val_w;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && (in_data_i.operation == OP_CONVERT)) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (chk_status.done) begin
          state_d = chk_status.ok ? S_DIVIDE : S_IDLE;
        end
      end
      S_DIVIDE: begin
        if (div_done && !div_nz) begin
          state_d = neg_q ? S_SIGN : S_STACK;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          state_d = S_STACK;
        end
      end
      S_STACK: state_d = S_TABLE;
      S_TABLE: state_d = S_PUT;
      S_PUT: begin
        if (slot_free) begin
          state_d = (dcnt_q == DCNT_W'(1)) ? S_IDLE : S_STACK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o   = 1'b0;
    chk_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = mag_q;
    stk_wr       = 1'b0;
    stk_rd       = 1'b0;
    tbl_rd       = 1'b0;
    out_load     = 1'b0;
    out_d        = '{out_char: ram_data, last: (dcnt_q == DCNT_W'(1))};
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        chk_start  = in_xfer && (in_data_i.operation == OP_CONVERT);
      end
      S_CHECK: begin
        div_start = chk_status.done && chk_status.ok;
      end
      S_DIVIDE: begin
        div_dividend = div_quot;
        stk_wr       = div_done;
        div_start    = div_done && div_nz;
      end
      S_SIGN: begin
        out_load = slot_free;
        out_d    = '{out_char: CHAR_MINUS, last: 1'b0};
      end
      S_STACK: stk_rd = 1'b1;
      S_TABLE: tbl_rd = 1'b1;
      S_PUT:   out_load = slot_free;
      default: ;
    endcase
  end

  // Symbol table port sharing: the checker reads during the check, the
  // sequencer reads while characters go out; loads write only when idle.
  assign ram_wr = in_xfer && (in_data_i.operation == OP_LOAD) &&
                  (int'(in_data_i.symbol_index) < MAX_RADIX);
  assign ram_rd      = chk_rd || tbl_rd;
  assign ram_rd_addr = tbl_rd ? stk_rd_q : chk_addr;

  rits_symbol_ram #(
    .MAX_RADIX (MAX_RADIX)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr),
    .wr_addr_i (IDX_W'(in_data_i.symbol_index)),
    .wr_data_i (in_data_i.symbol_code),
    .rd_en_i   (ram_rd),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_data)
  );

  rits_base_check #(
    .MAX_RADIX (MAX_RADIX)
  ) u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (chk_start),
    .radix_i   (radix_q),
    .rd_en_o   (chk_rd),
    .rd_addr_o (chk_addr),
    .rd_data_i (ram_data),
    .status_o  (chk_status)
  );

  rits_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (radix_q),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem),
    .nonzero_o   (div_nz)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radix_q     <= RADIX_RESET;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        radix_q <= cfg_data_i;
      end
      if (state_q == S_CHECK) begin
        dcnt_q <= '0;
      end else if (stk_wr) begin
        dcnt_q <= dcnt_q + 1'b1;
      end else if (out_load && (state_q == S_PUT)) begin
        dcnt_q <= dcnt_m1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: sign, magnitude and the output character.
  always_ff @(posedge clk_i) begin
    if (chk_start) begin
      neg_q <= val_w[VALUE_WIDTH-1];
      mag_q <= val_mag;
    end
    if (out_load) begin
      out_data_q <= out_d;
    end
  end

  // Digit stack: remainders pushed least significant first, popped in
  // reverse order through a registered read.
  always_ff @(posedge clk_i) begin
    if (stk_wr) begin
      stk_mem[dcnt_q[STK_W-1:0]] <= DIG_W'(div_rem);
    end
    if (stk_rd) begin
      stk_rd_q <= stk_mem[dcnt_m1[STK_W-1:0]];
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A check result arrives only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_status.done |-> (state_q == S_CHECK))
    else $error("base check finished outside the check phase");

  // The digit count never passes the stack depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(dcnt_q) <= VALUE_WIDTH)
    else $error("digit stack overflow");

  // A character is popped only while digits remain on the stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_STACK) || (state_q == S_PUT)) |-> (dcnt_q != '0))
    else $error("digit stack underflow");

  // Once the final character is loaded, the next item may enter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.last) |=> in_ready_o)
    else $error("sequencer not idle after the final character");

endmodule

@@ hw/rtl/rits_symbol_ram.sv @@
// Symbol table memory: one write port and one registered read port.
// Depends on rits_pkg for the character width.
`timescale 1ns / 1ps

module rits_symbol_ram import rits_pkg::*; #(
  parameter int MAX_RADIX = MAX_RADIX_DEF
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_RADIX)-1:0] wr_addr_i,
  input  logic [CHAR_W-1:0]            wr_data_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_RADIX)-1:0] rd_addr_i,
  output logic [CHAR_W-1:0]            rd_data_o
);

  logic [CHAR_W-1:0] mem [MAX_RADIX];
  logic [CHAR_W-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/rits_base_check.sv @@
// Base check: walks the symbols in use, one per cycle, and flags reserved
// codes and duplicates with a bitmap of codes seen. Depends on rits_pkg.
`timescale 1ns / 1ps

module rits_base_check import rits_pkg::*; #(
  parameter int MAX_RADIX = MAX_RADIX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [RADIX_W-1:0]           radix_i,
  output logic                         rd_en_o,
  output logic [$clog2(MAX_RADIX)-1:0] rd_addr_o,
  input  logic [CHAR_W-1:0]            rd_data_i,
  output rits_check_t                  status_o
);

  localparam int IDX_W = $clog2(MAX_RADIX);
  localparam int CNT_W = IDX_W + 1;
  localparam int CODES = 1 << CHAR_W;

  logic             busy_q, pend_q, ok_q, done_q;
  logic [CNT_W-1:0] cnt_q, limit_q;
  logic [CODES-1:0] seen_q;
  logic             range_ok, issue, bad;

  // The radix itself must lie from 2 up to MAX_RADIX, the table size.
  assign range_ok = (radix_i >= RADIX_W'(2)) && (int'(radix_i) <= MAX_RADIX);

  assign issue     = busy_q && (cnt_q != limit_q);
  assign rd_en_o   = issue;
  assign rd_addr_o = cnt_q[IDX_W-1:0];

  // The symbol read in the previous cycle is checked against the reserved codes
  // and against every code already seen.
  assign bad = (rd_data_i == CHAR_NUL) || (rd_data_i == CHAR_PLUS) ||
               (rd_data_i == CHAR_MINUS) || seen_q[rd_data_i];

  // Control of the walk over the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pend_q  <= 1'b0;
      ok_q    <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      limit_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= range_ok;
        done_q  <= !range_ok;
        ok_q    <= range_ok;
        pend_q  <= 1'b0;
        cnt_q   <= '0;
        limit_q <= CNT_W'(radix_i);
      end else if (busy_q) begin
        pend_q <= issue;
        if (issue) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (pend_q && bad) begin
          ok_q <= 1'b0;
        end
        if (!issue && !pend_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Bitmap of codes seen, cleared at the start of each check.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      seen_q <= '0;
    end else if (busy_q && pend_q) begin
      seen_q[rd_data_i] <= 1'b1;
    end
  end

  assign status_o = '{done: done_q, ok: ok_q};

endmodule

@@ hw/rtl/rits_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, giving the
// quotient, the remainder and whether the quotient is nonzero. Uses rits_pkg.
`timescale 1ns / 1ps

module rits_divider import rits_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [RADIX_W-1:0]     divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [RADIX_W-1:0]     remainder_o,
  output logic                   nonzero_o
);

  localparam int STEP_W = $clog2(VALUE_WIDTH + 1);

  logic                   busy_q, done_q, nz_q;
  logic [STEP_W-1:0]      step_q;
  logic [VALUE_WIDTH-1:0] dvd_q;
  logic [RADIX_W-1:0]     rem_q;
  logic [RADIX_W:0]       trial, diff;
  logic                   ge;

  // One restoring step: bring down the next dividend bit and subtract
  // the divisor where it fits.
  assign trial = {rem_q, dvd_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(VALUE_WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register turns into the quotient bit by bit.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      nz_q  <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[VALUE_WIDTH-2:0], ge};
      rem_q <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      nz_q  <= nz_q | ge;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;
  assign nonzero_o   = nz_q;

endmodule

@@ verif/radix_integer_to_symbols_tb.sv @@
// Self-checking testbench for radix_integer_to_symbols: random and directed
// load and convert items, checked against an in-bench digit predictor.
// Depends on rits_pkg and the radix_integer_to_symbols top level.
`timescale 1ns / 1ps

module radix_integer_to_symbols_tb;
  import rits_pkg::*;

  // Settling time, longer than the longest conversion without stalls.
  localparam int DRAIN_CYCLES   = 1300;
  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk_i;
  logic               rst_ni     = 1'b0;
  logic               in_valid   = 1'b0;
  rits_in_t           in_data    = '0;
  logic               out_ready  = 1'b1;
  logic               cfg_valid  = 1'b0;
  logic [RADIX_W-1:0] cfg_data   = '0;
  logic               in_ready_o;
  logic               out_valid_o;
  rits_out_t          out_data_o;
  logic               cfg_ready_o;

  // Flags for the transfers seen at the last rising edge.
  logic in_took  = 1'b0;
  logic cfg_took = 1'b0;

  // Stimulus side: items waiting to be driven and the planned table.
  rits_in_t       pending_items[$];
  logic [7:0]     plan_table[MAX_RADIX_DEF];
  bit             plan_written[MAX_RADIX_DEF];
  int             items_queued = 0;
  bit             jitter = 1'b1;
  int             in_gap = 0;
  int             out_stall = 0;

  // Prediction side: own copy of the table and radix, expected characters.
  logic [7:0]         model_table[MAX_RADIX_DEF];
  logic [RADIX_W-1:0] model_radix = RADIX_RESET;
  rits_out_t          expected_chars[$];
  int                 items_taken = 0;
  int                 chars_checked = 0;
  int                 rejected_bases = 0;
  int                 radix_settings = 0;
  int                 fails = 0;
  int                 quiet_cycles = 0;

  radix_integer_to_symbols dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // A base is usable when the radix fits the table and its symbols are
  // all legal and distinct.
  function automatic bit base_usable();
    if (model_radix < 2 || model_radix > MAX_RADIX_DEF) return 1'b0;
    for (int i = 0; i < model_radix; i++) begin
      if (model_table[i] == CHAR_NUL || model_table[i] == CHAR_PLUS ||
          model_table[i] == CHAR_MINUS) return 1'b0;
      for (int j = i + 1; j < model_radix; j++) begin
        if (model_table[j] == model_table[i]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Work out the characters that one accepted item produces.
  function automatic void predict_chars(input rits_in_t item);
    logic [31:0] mag;
    logic [5:0]  digits[$];
    rits_out_t   ch;
    if (item.operation == OP_LOAD) begin
      model_table[item.symbol_index] = item.symbol_code;
      return;
    end
    if (!base_usable()) begin
      rejected_bases++;
      return;
    end
    // The most negative value converts as its unsigned magnitude.
    mag = item.value[VALUE_W-1] ? 32'(-item.value) : 32'(item.value);
    do begin
      digits.push_front(6'(mag % model_radix));
      mag = mag / model_radix;
    end while (mag != 0);
    if (item.value[VALUE_W-1]) begin
      ch.out_char = CHAR_MINUS;
      ch.last     = 1'b0;
      expected_chars.push_back(ch);
    end
    foreach (digits[k]) begin
      ch.out_char = model_table[digits[k]];
      ch.last     = (k == digits.size() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  // Monitor: sample every handshake at the rising edge.
  always @(posedge clk_i) begin
    rits_out_t want;
    if (rst_ni) begin
      in_took  <= in_valid && in_ready_o;
      cfg_took <= cfg_valid && cfg_ready_o;
      if (in_valid && in_ready_o) begin
        predict_chars(in_data);
        items_taken++;
      end
      if (cfg_valid && cfg_ready_o) model_radix = cfg_data;
      if (out_valid_o && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character %02h (last %0b)", out_data_o.out_char,
                 out_data_o.last);
          fails++;
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (out_data_o.out_char !== want.out_char) begin
            $error("out_char mismatch: expected %02h, got %02h", want.out_char,
                   out_data_o.out_char);
            fails++;
          end
          if (out_data_o.last !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, out_data_o.last);
            fails++;
          end
        end
      end
      // Watchdog on stretches with no transfer at all.
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
          (cfg_valid && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("no transfer for %0d cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Driver: present items and back-pressure at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_took) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (jitter && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (jitter && $urandom_range(0, 7) == 0) out_stall = $urandom_range(1, 13);
      end
    end
  end

  task automatic queue_load(input int idx, input logic [7:0] code);
    rits_in_t item;
    item.operation    = OP_LOAD;
    item.symbol_index = 6'(idx);
    item.symbol_code  = code;
    item.value        = $urandom;
    plan_table[idx]   = code;
    plan_written[idx] = 1'b1;
    pending_items.push_back(item);
    items_queued++;
  endtask

  task automatic queue_convert(input logic signed [31:0] v);
    rits_in_t item;
    item.operation    = OP_CONVERT;
    item.symbol_index = 6'($urandom);
    item.symbol_code  = 8'($urandom);
    item.value        = v;
    pending_items.push_back(item);
    items_queued++;
  endtask

  // A legal symbol not yet used in positions below r, other than at skip.
  function automatic logic [7:0] unused_symbol(input int r, input int skip);
    logic [7:0] c;
    bit         clash;
    do begin
      c     = 8'($urandom);
      clash = (c == CHAR_NUL) || (c == CHAR_PLUS) || (c == CHAR_MINUS);
      for (int j = 0; j < r; j++) begin
        if (j != skip && plan_written[j] && plan_table[j] == c) clash = 1'b1;
      end
    end while (clash);
    return c;
  endfunction

  // Rewrite whatever entries keep a base of radix r from being valid.
  task automatic make_base_valid(input int r);
    bit bad;
    for (int i = 0; i < r; i++) begin
      bad = !plan_written[i] || plan_table[i] == CHAR_NUL ||
            plan_table[i] == CHAR_PLUS || plan_table[i] == CHAR_MINUS;
      for (int j = 0; j < i; j++) begin
        if (plan_table[j] == plan_table[i]) bad = 1'b1;
      end
      if (bad) queue_load(i, unused_symbol(r, i));
    end
  endtask

  // Values spread over random words, extremes, small numbers and powers of the radix.
  function automatic logic signed [31:0] pick_value(input int r);
    longint                p;
    int                    k;
    logic signed [31:0]    v;
    p = 1;
    k = $urandom_range(0, 32);
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 2 * r);
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 0;
          default: v = -1;
        endcase
      end
      3: begin
        while (k > 0 && r >= 2 && p * r <= 64'sh7fff_ffff) begin
          p = p * r;
          k--;
        end
        v = 32'(p) - 32'($urandom_range(0, 1));
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Mostly conversions on a valid base; a stray load that may break the
  // base is followed a few items later by a load that repairs it.
  task automatic random_items(input int r, input int n);
    bit valid_r;
    int repair_idx;
    int repair_wait;
    int sel;
    int idx;
    valid_r     = (r >= 2 && r <= MAX_RADIX_DEF);
    repair_idx  = -1;
    repair_wait = 0;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (repair_idx >= 0 && repair_wait == 0) begin
        queue_load(repair_idx, unused_symbol(r, repair_idx));
        repair_idx = -1;
      end else if (sel < 70 || (sel >= 88 && repair_idx >= 0)) begin
        queue_convert(pick_value(r));
      end else if (sel < 88 && valid_r) begin
        idx = $urandom_range(0, r - 1);
        queue_load(idx, unused_symbol(r, idx));
      end else begin
        idx = $urandom_range(0, MAX_RADIX_DEF - 1);
        queue_load(idx, 8'($urandom));
        if (valid_r && idx < r) begin
          repair_idx  = idx;
          repair_wait = $urandom_range(0, 3);
        end
      end
      if (repair_wait > 0) repair_wait--;
    end
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(negedge clk_i); while (!cfg_took);
    cfg_valid <= 1'b0;
    radix_settings++;
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || expected_chars.size() != 0) @(negedge clk_i);
  endtask

  // One setting of the radix: settle, write it, then random traffic.
  task automatic run_phase(input int r, input int n, input bit jit);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    write_radix(RADIX_W'(r));
    @(posedge clk_i);
    jitter = jit;
    if (r >= 2 && r <= MAX_RADIX_DEF) make_base_valid(r);
    random_items(r, n);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_radix(RADIX_RESET);
    @(posedge clk_i);

    // Decimal digits, then extremes of the value and of the symbol code.
    for (int i = 0; i < 10; i++) queue_load(i, 8'h30 + 8'(i));
    queue_load(MAX_RADIX_DEF - 1, 8'hff);
    queue_load(MAX_RADIX_DEF - 2, CHAR_NUL);
    queue_convert(0);
    queue_convert(7);
    queue_convert(-1);
    queue_convert(10);
    queue_convert(32'sh7fff_ffff);
    queue_convert(32'sh8000_0000);
    // Illegal symbols and a duplicate in use reject the base.
    queue_load(4, CHAR_PLUS);
    queue_convert(99);
    queue_load(4, CHAR_MINUS);
    queue_convert(99);
    queue_load(4, CHAR_NUL);
    queue_convert(99);
    queue_load(4, 8'h39);
    queue_convert(99);
    queue_load(4, 8'h34);
    queue_convert(-4096);
    random_items(10, 70);

    run_phase(2, 25, 1'b1);
    run_phase(MAX_RADIX_DEF, 70, 1'b1);
    run_phase(0, 6, 1'b1);
    run_phase(1, 6, 1'b1);
    run_phase(127, 6, 1'b1);
    run_phase(MAX_RADIX_DEF + 1, 6, 1'b1);
    run_phase(16, 60, 1'b1);
    run_phase(36, 60, 1'b1);
    run_phase($urandom_range(3, MAX_RADIX_DEF - 1), 100, 1'b1);
    // Closing stretch at full rate on both sides.
    run_phase(7, 60, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_chars.size() != 0) begin
      $error("%0d expected characters never arrived", expected_chars.size());
      fails++;
    end
    $display("Drove %0d items over %0d radix settings, checked %0d characters.",
             items_taken, radix_settings, chars_checked);
    $display("Conversions turned away by an invalid base: %0d.", rejected_bases);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rits_pkg.sv
hw/rtl/rits_symbol_ram.sv
hw/rtl/rits_base_check.sv
hw/rtl/rits_divider.sv
hw/rtl/radix_integer_to_symbols.sv
verif/radix_integer_to_symbols_tb.sv
